>>> sv/integer_to_decimal_ascii_defines.svh
// Assertion macros for the decimal text generator.
`ifndef INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define ITDA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define ITDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/itda_pkg.sv
// Shared constants for the decimal text generator.
package itda_pkg;
  localparam int MAX_WIDTH_DEF = 32;
  localparam int VALUE_BITS    = 32;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] MINUS_SIGN = 8'd45;
  localparam logic [7:0] PAD_RESET  = 8'd32;
  localparam logic [1:0] REG_MIN_WIDTH   = 2'd0;
  localparam logic [1:0] REG_PAD_CHAR    = 2'd1;
  localparam logic [1:0] REG_SIGNED_MODE = 2'd2;
  localparam int CFG_IDX_W = 32;
  // Divide by ten as (q * DIV10_MUL) >> DIV10_SHIFT, exact for every 32-bit q
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;
endpackage

>>> sv/integer_to_decimal_ascii.sv
// An accepted request passes through the stage registers to its first character at the output register
// (one magnitude stage, nine divide-by-ten stages, then the emitter loads the text).
// Throughput: one character per cycle unless out_stall holds a full output register; an item holds the emitter for
// max(digits + sign, min_width clipped to MAX_WIDTH) characters, 1 to 32 with the defaults.
// Up to eleven requests are buffered; in_stall rises when every stage is full and the emitter is not finishing.
// Reset: synchronous active low; clears valids and sets min_width 0, pad 32, signed on.
`include "integer_to_decimal_ascii_defines.svh"
module integer_to_decimal_ascii #(
  parameter int MAX_WIDTH = itda_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_char,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [itda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import itda_pkg::*;

  localparam int NDIG = (VALUE_BITS * 302) / 1000 + 1;
  localparam int NDIV = NDIG - 1;
  localparam int DW   = NDIG * 4;
  localparam int PW   = NDIV * 4;
  localparam int SHW  = $clog2(DW);
  localparam int LW   = $clog2(NDIG + MAX_WIDTH + 2);
  localparam int DCW  = $clog2(NDIG + 1);

  logic [5:0] min_width_r;
  logic [7:0] pad_char_r;
  logic       signed_mode_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_width_r   <= '0;
      pad_char_r    <= PAD_RESET;
      signed_mode_r <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_W'(REG_MIN_WIDTH)) min_width_r <= cfg_data[5:0];
      else if (cfg_index == CFG_IDX_W'(REG_PAD_CHAR)) pad_char_r <= cfg_data[7:0];
      else if (cfg_index == CFG_IDX_W'(REG_SIGNED_MODE)) signed_mode_r <= cfg_data[0];
    end
  end

  // Stage 0 holds the magnitude; stage k holds the quotient after k divisions by ten
  logic [NDIV:0]           pv_r;
  logic [NDIV:0]           pneg_r;
  logic [VALUE_BITS-1:0]   q_r    [NDIV+1];
  logic [PW-1:0]           dg_r   [1:NDIV];
  logic [PW-1:0]           dg_nxt [1:NDIV];
  logic [2*VALUE_BITS-1:0] prod   [NDIV];
  logic [VALUE_BITS-1:0]   quo    [NDIV];
  logic [3:0]              rem    [NDIV];
  logic [NDIV+1:0]         rdy;

  // Emitter
  logic           e_v_r, e_neg_r;
  logic [DW-1:0]  e_dg_r;
  logic [LW-1:0]  pos_r, len_r, padn_r;
  logic           emit, e_done, e_rdy, e_load, e_is_dig, o_full;
  logic [7:0]     ch;
  logic [DW-1:0]  all_dg;
  logic [DCW-1:0] nd;
  logic [LW-1:0]  width_c, body_c;
  logic [SHW-1:0] sh_c;

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      prod[k] = (2*VALUE_BITS)'(q_r[k]) * (2*VALUE_BITS)'(DIV10_MUL);
      quo[k]  = VALUE_BITS'(prod[k] >> DIV10_SHIFT);
      rem[k]  = 4'(q_r[k] - (quo[k] << 3) - (quo[k] << 1));
    end
  end

  always_comb begin
    dg_nxt[1] = PW'(rem[0]);
    for (int k = 2; k <= NDIV; k++) begin
      dg_nxt[k] = dg_r[k-1];
      dg_nxt[k][(k-1)*4 +: 4] = rem[k-1];
    end
  end

  // a stage advances when it is empty or the one after it advances
  always_comb begin
    rdy[NDIV+1] = e_rdy;
    for (int k = NDIV; k >= 0; k--) rdy[k] = !pv_r[k] || rdy[k+1];
  end
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= '0;
    else begin
      if (rdy[0]) pv_r[0] <= in_valid;
      for (int k = 1; k <= NDIV; k++)
        if (rdy[k]) pv_r[k] <= pv_r[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pneg_r[0] <= signed_mode_r && in_value_bits[VALUE_BITS-1];
      q_r[0]    <= (signed_mode_r && in_value_bits[VALUE_BITS-1]) ?
                   (~in_value_bits[VALUE_BITS-1:0] + 1'b1) : in_value_bits[VALUE_BITS-1:0];
    end
    for (int k = 1; k <= NDIV; k++)
      if (rdy[k]) begin
        pneg_r[k] <= pneg_r[k-1];
        q_r[k]    <= quo[k-1];
        dg_r[k]   <= dg_nxt[k];
      end
  end

  // the last quotient is the top digit
  assign all_dg = {q_r[NDIV][3:0], dg_r[NDIV]};

  // digit count: highest nonzero digit
  always_comb begin
    nd = DCW'(1);
    for (int k = 1; k < NDIG; k++)
      if (all_dg[k*4 +: 4] != 4'd0) nd = DCW'(k + 1);
  end

  assign width_c = (int'(min_width_r) > MAX_WIDTH) ? LW'(MAX_WIDTH) : LW'(min_width_r);
  assign body_c  = LW'(nd) + LW'(pneg_r[NDIV]);
  assign sh_c    = SHW'((NDIG - int'(nd)) * 4);

  assign emit   = e_v_r && (!o_full || !out_stall);
  assign e_done = emit && (pos_r + 1'b1 == len_r);
  assign e_rdy  = !e_v_r || e_done;
  assign e_load = pv_r[NDIV] && e_rdy;

  always_comb begin
    e_is_dig = 1'b0;
    if (pos_r < padn_r) ch = pad_char_r;
    else if (e_neg_r && pos_r == padn_r) ch = MINUS_SIGN;
    else begin
      ch       = DIGIT_ZERO + {4'd0, e_dg_r[DW-1 -: 4]};
      e_is_dig = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (e_load) e_v_r <= 1'b1;
    else if (e_done) e_v_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (e_load) begin
      // left-align the digits so the leading one sits in the top nibble
      e_dg_r  <= all_dg << sh_c;
      e_neg_r <= pneg_r[NDIV];
      pos_r   <= '0;
      padn_r  <= (width_c > body_c) ? width_c - body_c : '0;
      len_r   <= (width_c > body_c) ? width_c : body_c;
    end else if (emit) begin
      pos_r <= pos_r + 1'b1;
      if (e_is_dig) e_dg_r <= e_dg_r << 4;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) o_full <= 1'b0;
    else if (emit) o_full <= 1'b1;
    else if (!out_stall) o_full <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (emit) begin
      out_out_char <= ch;
      out_last     <= pos_r + 1'b1 == len_r;
    end
  end
  assign out_valid = o_full;

  `ITDA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_out_char))
  `ITDA_ASSERT_IMPL(a_emit_room, emit, e_v_r)
  `ITDA_ASSERT_IMPL(a_stall_full, in_stall, pv_r[0])
endmodule

>>> test/itda_checker.sv
// Checker for the decimal text generator: predicts each character and compares.
`timescale 1ns / 100ps
module itda_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_value_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_out_char,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          chars_pending
);
  import itda_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t char_queue[$];
  logic [5:0] width_q;
  logic [7:0] pad_q;
  logic       signed_q;

  // Append the expected text of one value to the queue.
  task automatic push_text(input logic [31:0] raw);
    logic [31:0] mag;
    logic        neg;
    logic [7:0]  digits[$];
    int          width;
    int          body;
    text_char_t  t;
    neg = signed_q && raw[31];
    mag = neg ? (~raw + 32'd1) : raw;
    do begin
      digits.push_front(DIGIT_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    width = (width_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_q);
    body = digits.size() + (neg ? 1 : 0);
    if (neg) digits.push_front(MINUS_SIGN);
    for (int i = body; i < width; i++) digits.push_front(pad_q);
    foreach (digits[i]) begin
      t.ch = digits[i];
      t.last = (i == digits.size() - 1);
      char_queue.push_back(t);
    end
  endtask

  always @(posedge clk) begin
    text_char_t e;
    if (!rst_n) begin
      width_q <= 6'd0;
      pad_q <= PAD_RESET;
      signed_q <= 1'b1;
      fail_count <= 0;
      char_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          32'(REG_MIN_WIDTH):   width_q <= cfg_data[5:0];
          32'(REG_PAD_CHAR):    pad_q <= cfg_data[7:0];
          32'(REG_SIGNED_MODE): signed_q <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) push_text(in_value_bits);
      if (out_valid && !out_stall) begin
        if (char_queue.size() == 0) begin
          $display("%0t: unexpected char %h last %b", $time, out_out_char, out_last);
          fail_count <= fail_count + 1;
        end else begin
          e = char_queue.pop_front();
          if (e.ch !== out_out_char || e.last !== out_last) begin
            $display("%0t: expected char %h last %b, actual char %h last %b",
                     $time, e.ch, e.last, out_out_char, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    chars_pending = char_queue.size();
  end
endmodule

>>> test/tb_integer_to_decimal_ascii.sv
// Testbench top for the decimal text generator: stimulus, config phases and verdict.
`timescale 1ns / 100ps
module tb_integer_to_decimal_ascii;
  import itda_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_value_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_out_char;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          chars_pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_armed = 1'b0;
  int          hold_left = 0;

  always #5 clk = ~clk;

  integer_to_decimal_ascii dut (.*);

  itda_checker checker_i (.*);

  // Receiver: random stall, or a long hold-off when requested.
  always @(posedge clk) begin
    if (!hold_req) begin
      hold_armed <= 1'b0;
      hold_left <= 0;
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end else if (!hold_armed) begin
      hold_armed <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_value(input logic [31:0] v);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value_bits <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every predicted character has come out.
  task automatic drain_text;
    in_valid <= 1'b0;
    @(negedge clk);
    while (chars_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= 32'(idx);
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_format(input logic [31:0] w, input logic [31:0] p, input logic [31:0] s);
    write_reg(REG_MIN_WIDTH, w);
    write_reg(REG_PAD_CHAR, p);
    write_reg(REG_SIGNED_MODE, s);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(4))
      0: random_value = $urandom_range(9);
      1: random_value = $urandom_range(99999);
      2: random_value = -$urandom_range(1000);
      default: random_value = $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] corner[$];
    corner = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'hFFFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF6, 32'd1000000000,
               32'hAAAA_AAAA, 32'h5555_5555};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset format first, then the directed corners again under a second format.
    foreach (corner[i]) send_value(corner[i]);
    drain_text();
    set_format(32'd12, 32'h2A, 32'd0);
    foreach (corner[i]) send_value(corner[i]);
    drain_text();
    // Over-wide width saturates; oversize data keeps only low bits.
    set_format(32'hFFFF_FF3F, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd7);
    drain_text();
    write_reg(REG_UNUSED, 32'd5);
    cfg_valid <= 1'b0;
    send_value(32'hFFFF_FFFF);
    drain_text();

    // Receiver holds off while the sender keeps offering.
    set_format(32'd20, 32'h30, 32'd1);
    hold_req <= 1'b1;
    repeat (16) send_value($urandom);
    drain_text();
    hold_req <= 1'b0;

    send_idle_pct = 24; recv_idle_pct = 57;
    set_format(32'd0, 32'd32, 32'd1);
    repeat (30) send_value(random_value());
    drain_text();
    send_idle_pct = 57; recv_idle_pct = 24;
    set_format(32'd11, 32'hFF, 32'd0);
    repeat (30) send_value(random_value());
    drain_text();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_format(32'd33, 32'h01, 32'd1);
    repeat (26) send_value(random_value());
    drain_text();

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> sim.f
+incdir+sv
sv/itda_pkg.sv
sv/integer_to_decimal_ascii.sv
test/itda_checker.sv
test/tb_integer_to_decimal_ascii.sv
